// File: rtl/core/tdg_pkg.sv
// Package with the request and result types and the register map of the delay generator.
`default_nettype none
package tdg_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_IDLE  = 2'd3
  } opcode_t;

  localparam logic [1:0] ADDR_DELAY_HI  = 2'd0;
  localparam logic [1:0] ADDR_DELAY_MID = 2'd1;
  localparam logic [1:0] ADDR_DELAY_LO  = 2'd2;
  localparam logic [1:0] ADDR_CTRL      = 2'd3;

  localparam int CTRL_START_OUT1 = 0;
  localparam int CTRL_END_OUT1   = 1;
  localparam int CTRL_START_OUT2 = 2;
  localparam int CTRL_END_OUT2   = 3;
  localparam int CTRL_IRQ_EN     = 4;
  localparam int CTRL_FALLING    = 5;
  localparam int CTRL_START_POS  = 6;
  localparam int CTRL_END_POS    = 7;

  localparam logic [7:0] CTRL_RESET  = 8'hC0;
  localparam int         DELAY_BYTES = 3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] reg_address;
    logic [7:0] write_byte;
    logic       trigger_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       output_one;
    logic       output_two;
    logic       busy_flag;
    logic       interrupt_pulse;
  } result_t;

  // Output level: idle level set by negative polarities, inverted by any enabled event.
  function automatic logic out_level(input logic s_en, input logic e_en,
                                     input logic s_pos, input logic e_pos,
                                     input logic start_ev, input logic end_ev);
    logic inv;
    logic act;
    inv = (s_en && !s_pos) || (e_en && !e_pos);
    act = (s_en && start_ev) || (e_en && end_ev);
    return act ^ inv;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/triggered_delay_generator.sv
// Top level of the triggered delay generator: input register, request logic, result register.
//
//   channel | signals                                        | direction
//   in      | in_valid, in_stall, opcode, reg_address,       | request in
//           | write_byte, trigger_level                      |
//   out     | out_valid, out_stall, read_byte, output_one,   | result out
//           | output_two, busy_flag, interrupt_pulse         |
//
// One request is accepted per cycle while in_stall is low; each request is registered in the input
// register, processed in a single pass through the state logic and captured in the result
// register. The rate is set by that single pass.
// Reset is synchronous and active high and clears the control byte to 0xC0 and all counters.
// A stall on the output holds the result register and, once the input register is full,
// raises in_stall.
`default_nettype none
module triggered_delay_generator
  import tdg_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [1:0] reg_address,
  input  wire logic [7:0] write_byte,
  input  wire logic       trigger_level,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      read_byte,
  output logic            output_one,
  output logic            output_two,
  output logic            busy_flag,
  output logic            interrupt_pulse
);

  logic    item_valid;
  item_t   item;
  logic    out_ready;
  logic    fire;
  result_t res;
  result_t res_q;

  assign in_stall = item_valid && !out_ready;
  assign fire     = item_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.opcode        <= opcode;
      item.reg_address   <= reg_address;
      item.write_byte    <= write_byte;
      item.trigger_level <= trigger_level;
    end
  end

  tdg_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  tdg_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign read_byte       = res_q.read_byte;
  assign output_one      = res_q.output_one;
  assign output_two      = res_q.output_two;
  assign busy_flag       = res_q.busy_flag;
  assign interrupt_pulse = res_q.interrupt_pulse;

endmodule
`default_nettype wire

// File: rtl/core/tdg_core.sv
// Delay generator state registers and the single-pass logic that processes one request.
`default_nettype none
module tdg_core
  import tdg_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      res
);

  logic [7:0]             control_byte, control_byte_next;
  logic [COUNT_WIDTH-1:0] delay_value, delay_value_next;
  logic [COUNT_WIDTH-1:0] tick_counter, tick_counter_next;
  logic                   running, running_next;
  logic                   last_eff, last_eff_next;

  logic                   is_tick, is_write, is_read, wr_delay, wr_ctrl;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   tick_end, run_a, write_end, run_b;
  logic                   eff, start_ev, end_ev, delay_zero;
  logic [7:0]             rd_lane [DELAY_BYTES];
  logic [7:0]             rbyte;

  assign is_tick  = item.opcode == OP_TICK;
  assign is_write = item.opcode == OP_WRITE;
  assign is_read  = item.opcode == OP_READ;
  assign wr_ctrl  = is_write && (item.reg_address == ADDR_CTRL);
  assign wr_delay = is_write && (item.reg_address != ADDR_CTRL);

  assign cnt_dec  = tick_counter - COUNT_WIDTH'(1);
  assign tick_end = is_tick && running && (cnt_dec == '0);
  assign run_a    = running && !tick_end;

  assign control_byte_next = wr_ctrl ? item.write_byte : control_byte;

  // Each delay bit below 8*DELAY_BYTES belongs to one byte lane; lane L is written at address 2 - L.
  for (genvar i = 0; i < COUNT_WIDTH; i++) begin : g_wr
    localparam int Lane = i / 8;
    if (Lane < DELAY_BYTES) begin : g_lane
      assign delay_value_next[i] =
        (wr_delay && (item.reg_address == 2'(DELAY_BYTES - 1 - Lane)))
          ? item.write_byte[i % 8] : delay_value[i];
    end else begin : g_none
      assign delay_value_next[i] = delay_value[i];
    end
  end

  assign write_end  = wr_delay && run_a;
  assign run_b      = run_a && !wr_delay;

  assign eff        = item.trigger_level ^ control_byte_next[CTRL_FALLING];
  assign start_ev   = eff && !last_eff;
  assign delay_zero = delay_value_next == '0;

  assign last_eff_next = eff;
  assign end_ev        = tick_end || write_end || (start_ev && delay_zero);

  always_comb begin
    tick_counter_next = tick_counter;
    running_next      = run_b;
    if (is_tick && running) begin
      tick_counter_next = cnt_dec;
    end
    if (start_ev) begin
      tick_counter_next = delay_value_next;
      running_next      = !delay_zero;
    end
  end

  for (genvar l = 0; l < DELAY_BYTES; l++) begin : g_rd_lane
    for (genvar j = 0; j < 8; j++) begin : g_rd_bit
      if (l * 8 + j < COUNT_WIDTH) begin : g_have
        assign rd_lane[l][j] = delay_value_next[l * 8 + j];
      end else begin : g_zero
        assign rd_lane[l][j] = 1'b0;
      end
    end
  end

  always_comb begin
    rbyte = '0;
    if (is_read) begin
      case (item.reg_address)
        ADDR_DELAY_HI:  rbyte = rd_lane[2];
        ADDR_DELAY_MID: rbyte = rd_lane[1];
        ADDR_DELAY_LO:  rbyte = rd_lane[0];
        ADDR_CTRL:      rbyte = {6'b0, running_next, 1'b0};
        default:        rbyte = '0;
      endcase
    end
  end

  always_comb begin
    res.read_byte       = rbyte;
    res.output_one      = out_level(control_byte_next[CTRL_START_OUT1],
                                    control_byte_next[CTRL_END_OUT1],
                                    control_byte_next[CTRL_START_POS],
                                    control_byte_next[CTRL_END_POS], start_ev, end_ev);
    res.output_two      = out_level(control_byte_next[CTRL_START_OUT2],
                                    control_byte_next[CTRL_END_OUT2],
                                    control_byte_next[CTRL_START_POS],
                                    control_byte_next[CTRL_END_POS], start_ev, end_ev);
    res.busy_flag       = running_next;
    res.interrupt_pulse = end_ev && control_byte_next[CTRL_IRQ_EN];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte <= CTRL_RESET;
      delay_value  <= '0;
      tick_counter <= '0;
      running      <= 1'b0;
      last_eff     <= 1'b0;
    end else if (fire) begin
      control_byte <= control_byte_next;
      delay_value  <= delay_value_next;
      tick_counter <= tick_counter_next;
      running      <= running_next;
      last_eff     <= last_eff_next;
    end
  end

`ifndef ASSERT_OFF
  // A running delay always has ticks left to count.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    running |-> tick_counter != '0)
    else $error("running with a zero counter");

  // State only changes when a request is processed.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(running) && $stable(tick_counter) && $stable(delay_value))
    else $error("state changed without a request");

  // The busy flag reported for a request is the busy state left behind.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    fire |=> running == $past(res.busy_flag))
    else $error("busy flag differs from stored state");
`endif

endmodule
`default_nettype wire

// File: rtl/core/tdg_out_stage.sv
// Result register with valid and stall toward the consumer.
`default_nettype none
module tdg_out_stage
  import tdg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      res_out
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire
